>>> sv/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Types, register indexes and helpers shared by the search-and-replace core.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int MaxPattern = 8;
    localparam int WinBytes   = 8;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [7:0] CFG_PATTERN_BYTES      = 8'd0;
    localparam logic [7:0] CFG_PATTERN_LENGTH     = 8'd1;
    localparam logic [7:0] CFG_REPLACEMENT_BYTES  = 8'd2;
    localparam logic [7:0] CFG_REPLACEMENT_LENGTH = 8'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } t_cfg;

    // A burst of up to eight bytes for the back end; count zero with last set
    // is the empty closing transaction.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_cmd;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < WinBytes; i++) begin
            if (4'(i) < len) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] eff_pattern_len(input logic [3:0] len);
        logic [3:0] n;
        n = len;
        if (n == 4'd0) begin
            n = 4'd1;
        end
        if (n > 4'(MaxPattern)) begin
            n = 4'(MaxPattern);
        end
        return n;
    endfunction

    function automatic logic [3:0] eff_repl_len(input logic [3:0] len);
        return (len > 4'd8) ? 4'd8 : len;
    endfunction

endpackage

>>> sv/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front
// Accepts text bytes, keeps the match window and decides per byte which output
// burst, if any, it yields: replacement, oldest window byte, or flush on last.
// ----------------------------------------------------------------------------
module ssr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ssr_pkg::t_in  i_in,
    input  ssr_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output ssr_pkg::t_cmd o_cmd
);
    import ssr_pkg::*;

    logic [63:0] r_win;
    logic [3:0]  r_fill;
    logic [63:0] n_win;
    logic [3:0]  n_fill;

    logic        accept;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  drop;
    logic [3:0]  fill_d;
    logic [3:0]  fill_n;
    logic [63:0] w_sh;
    logic [63:0] w_ins;
    logic        full;
    logic        match;

    assign accept = i_valid && !i_q_full;
    assign plen   = eff_pattern_len(i_cfg.pattern_length);
    assign rlen   = eff_repl_len(i_cfg.replacement_length);

    always_comb begin
        if (r_fill >= plen) begin
            drop   = r_fill - (plen - 4'd1);
            fill_d = plen - 4'd1;
        end else begin
            drop   = 4'd0;
            fill_d = r_fill;
        end
        w_sh  = r_win >> {drop, 3'b000};
        w_ins = w_sh;
        w_ins[{fill_d[2:0], 3'b000} +: 8] = i_in.text_byte;
        fill_n = fill_d + 4'd1;
        full   = (fill_n == plen);
        match  = full && (((w_ins ^ i_cfg.pattern_bytes) & byte_mask(plen)) == 64'd0);
    end

    always_comb begin
        o_cmd.last = i_in.text_last;
        o_cmd.data = w_ins;
        o_cmd.count = 4'd0;
        o_push     = 1'b0;
        n_win      = w_ins;
        n_fill     = 4'd0;
        if (match) begin
            o_cmd.data  = i_cfg.replacement_bytes;
            o_cmd.count = rlen;
            o_push      = accept && ((rlen != 4'd0) || i_in.text_last);
        end else if (full) begin
            o_push = accept;
            if (i_in.text_last) begin
                o_cmd.count = plen;
            end else begin
                o_cmd.count = 4'd1;
                n_win       = w_ins >> 8;
                n_fill      = plen - 4'd1;
            end
        end else begin
            if (i_in.text_last) begin
                o_cmd.count = fill_n;
                o_push      = accept;
            end else begin
                n_fill = fill_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 4'd0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

>>> sv/ssr_cmd_queue.sv
// ----------------------------------------------------------------------------
// ssr_cmd_queue
// Short burst queue between the front and back ends.
// ----------------------------------------------------------------------------
module ssr_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output ssr_pkg::t_cmd o_head
);
    import ssr_pkg::*;

    t_cmd                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr;
    logic [QueuePtrW-1:0] r_rd;
    logic [QueueCntW-1:0] r_cnt;

    logic do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QueueCntW'(QueueDepth));
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QueuePtrW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QueuePtrW'(1);
            end
            r_cnt <= r_cnt + QueueCntW'(i_push) - QueueCntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back
// Serializes queued bursts into one output byte per transaction through an
// output register.
// ----------------------------------------------------------------------------
module ssr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ssr_pkg::t_cmd i_q_head,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output ssr_pkg::t_out o_out
);
    import ssr_pkg::*;

    logic [2:0] r_idx;
    logic       r_vld;
    t_out       r_out;

    logic       load;
    logic       take;
    logic       at_end;
    logic       empty;
    t_out       n_out;

    assign load   = !r_vld || !i_stall;
    assign take   = load && i_q_valid;
    assign empty  = (i_q_head.count == 4'd0);
    assign at_end = empty || ({1'b0, r_idx} == (i_q_head.count - 4'd1));
    assign o_pop  = take && at_end;

    always_comb begin
        n_out.out_byte  = empty ? 8'd0 : i_q_head.data[{r_idx, 3'b000} +: 8];
        n_out.out_valid = !empty;
        n_out.out_last  = i_q_head.last && at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_vld <= i_q_valid;
            end
            if (take) begin
                r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_out   = r_out;

endmodule

>>> sv/stream_search_and_replace_core.sv
// ----------------------------------------------------------------------------
// stream_search_and_replace_core
// Rewrites a byte stream, replacing every non-overlapping pattern occurrence.
// Path: accepted bytes pass through the burst queue, then the back-end output register.
// Throughput: one input byte per cycle while the queue has room; output one byte per
// cycle unless i_stall holds it, set by the back-end serializer, which stalls input through a 4-burst queue.
// Reset: synchronous active low; clears window fill, queue and output valid, and resets the rule.
// ----------------------------------------------------------------------------
module stream_search_and_replace_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ssr_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output ssr_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import ssr_pkg::*;

    t_cfg r_cfg;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    t_cmd cmd;
    t_cmd q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes      <= 64'd0;
            r_cfg.pattern_length     <= 4'd1;
            r_cfg.replacement_bytes  <= 64'd0;
            r_cfg.replacement_length <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_BYTES:      r_cfg.pattern_bytes      <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_cfg.pattern_length     <= i_cfg_data[3:0];
                CFG_REPLACEMENT_BYTES:  r_cfg.replacement_bytes  <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_cfg.replacement_length <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_stall = q_full;

    ssr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    ssr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    ssr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_out     (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("burst pushed into full queue");

    a_empty_burst_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && cmd.count == 4'd0) |-> cmd.last)
        else $error("empty burst without last");

    a_burst_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (cmd.count <= 4'd8))
        else $error("burst longer than eight bytes");

    a_empty_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.out_valid) |-> o_out.out_last)
        else $error("empty result without last");

endmodule

>>> dv/stream_search_and_replace_core_test.sv
// ----------------------------------------------------------------------------
// stream_search_and_replace_core_test
// Self-checking bench for the search-and-replace core. A queue-fed driver
// offers text bytes, a monitor rebuilds the rewritten stream from its own
// window model and compares every output transaction in order. Directed texts
// cover the edge settings, then random texts with embedded and broken pattern
// occurrences run under changing rules, pacing and a long output hold-off.
// ----------------------------------------------------------------------------
module stream_search_and_replace_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int HalfPeriod  = 4;
    localparam int ResetCycles = 11;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 400000;
    localparam int LongHold    = 300;
    localparam int MaxGap      = 17;
    localparam int Phases      = 6;
    localparam int PhaseBytes  = 30;

    localparam logic [7:0] CFG_UNUSED_LOW  = 8'd4;
    localparam logic [7:0] CFG_UNUSED_HIGH = 8'hFF;

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in         i_in       = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out        o_out;
    logic        i_cfg_we   = 1'b0;
    logic [7:0]  i_cfg_idx  = '0;
    logic [63:0] i_cfg_data = '0;

    logic [63:0] cfg_pattern = '0;
    logic [3:0]  cfg_plen    = 4'd1;
    logic [63:0] cfg_repl    = '0;
    logic [3:0]  cfg_rlen    = 4'd0;
    logic [7:0]  win_bytes [MaxPattern];
    int          win_fill    = 0;

    t_in  text_pending [$];
    t_out rewritten_q [$];
    logic [7:0] alphabet [4];

    bit    in_taken      = 1'b0;
    bit    out_taken     = 1'b0;
    t_pace send_pace     = PACE_STEADY;
    t_pace recv_pace     = PACE_STEADY;
    int    tx_gap        = 0;
    int    rx_gap        = 0;
    int    rx_hold       = 0;
    int    long_hold_req = 0;
    int    queued        = 0;
    int    accepted      = 0;
    int    bytes_out     = 0;
    int    rule_count    = 0;
    int    mismatches    = 0;
    int    cycle_count   = 0;

    stream_search_and_replace_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #HalfPeriod i_clk = ~i_clk;

    function automatic int draw_gap(input t_pace pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, MaxGap);
            default:     return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MaxGap) : 0;
        endcase
    endfunction

    function automatic int pattern_span();
        if (cfg_plen == 4'd0) begin
            return 1;
        end
        return (cfg_plen > MaxPattern) ? MaxPattern : int'(cfg_plen);
    endfunction

    function automatic t_out result_of(input logic [7:0] b, input logic carries);
        return '{out_byte: b, out_valid: carries, out_last: 1'b0};
    endfunction

    function automatic void drop_oldest(input int n);
        for (int i = 0; i + n < win_fill; i++) begin
            win_bytes[i] = win_bytes[i + n];
        end
        win_fill -= n;
    endfunction

    task automatic rewrite_byte(input t_in item);
        int   plen;
        int   rlen;
        bit   hit;
        t_out burst [$];
        plen = pattern_span();
        rlen = (cfg_rlen > 4'd8) ? 8 : int'(cfg_rlen);
        if (win_fill >= plen) begin
            drop_oldest(win_fill - plen + 1);
        end
        win_bytes[win_fill] = item.text_byte;
        win_fill++;
        if (win_fill == plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
                if (win_bytes[i] != cfg_pattern[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (int i = 0; i < rlen; i++) begin
                    burst.push_back(result_of(cfg_repl[8*i +: 8], 1'b1));
                end
                win_fill = 0;
            end else begin
                burst.push_back(result_of(win_bytes[0], 1'b1));
                drop_oldest(1);
            end
        end
        if (item.text_last) begin
            for (int i = 0; i < win_fill; i++) begin
                burst.push_back(result_of(win_bytes[i], 1'b1));
            end
            win_fill = 0;
            if (burst.size() == 0) begin
                burst.push_back(result_of(8'h00, 1'b0));
            end
            burst[burst.size() - 1].out_last = 1'b1;
        end
        foreach (burst[i]) begin
            rewritten_q.push_back(burst[i]);
        end
    endtask

    // input side: hold a stalled transaction, otherwise wait out the gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (in_taken) begin
                tx_gap = draw_gap(send_pace);
            end
            if (!i_valid || in_taken) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (text_pending.size() > 0) begin
                    i_in    <= text_pending.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side: long hold-off first, then per-transaction gaps
    always @(negedge i_clk) begin
        if (long_hold_req > 0) begin
            rx_hold       = long_hold_req;
            long_hold_req = 0;
        end
        if (out_taken) begin
            rx_gap = draw_gap(recv_pace);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        in_taken  = i_rst_n && i_valid && !o_stall;
        out_taken = i_rst_n && o_valid && !i_stall;
        if (out_taken) begin
            if (rewritten_q.size() == 0) begin
                $error("unexpected transaction: out_byte %02h out_valid %0b out_last %0b",
                       o_out.out_byte, o_out.out_valid, o_out.out_last);
                mismatches++;
            end else begin
                want = rewritten_q.pop_front();
                bytes_out++;
                if (o_out.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, o_out.out_byte);
                    mismatches++;
                end
                if (o_out.out_valid !== want.out_valid) begin
                    $error("out_valid: expected %0b, got %0b", want.out_valid, o_out.out_valid);
                    mismatches++;
                end
                if (o_out.out_last !== want.out_last) begin
                    $error("out_last: expected %0b, got %0b", want.out_last, o_out.out_last);
                    mismatches++;
                end
            end
        end
        if (in_taken) begin
            rewrite_byte(i_in);
            accepted++;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        text_pending.push_back('{text_byte: b, text_last: last});
        queued++;
    endtask

    // mix whole occurrences, broken ones, alphabet bytes and noise
    task automatic queue_text(input int len, input bit close);
        int         plen;
        int         piece;
        int         run_pos;
        int         run_left;
        bit         broken;
        logic [7:0] b;
        plen     = pattern_span();
        piece    = 0;
        run_pos  = 0;
        run_left = 0;
        broken   = 1'b0;
        for (int n = 0; n < len; n++) begin
            if (run_left == 0) begin
                piece    = $urandom_range(0, 9);
                run_pos  = 0;
                broken   = (piece == 5);
                run_left = (piece < 5) ? plen : (broken ? $urandom_range(1, plen) : 0);
            end
            if (run_left > 0) begin
                b = cfg_pattern[8*run_pos +: 8];
                if (broken && run_left == 1) begin
                    b = b ^ 8'($urandom_range(1, 255));
                end
                run_pos++;
                run_left--;
            end else if (piece < 9) begin
                b = alphabet[$urandom_range(0, 3)];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            queue_byte(b, close && n == len - 1);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (accepted != queued || rewritten_q.size() != 0);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_BYTES:      cfg_pattern = value;
            CFG_PATTERN_LENGTH:     cfg_plen    = value[3:0];
            CFG_REPLACEMENT_BYTES:  cfg_repl    = value;
            CFG_REPLACEMENT_LENGTH: cfg_rlen    = value[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rule(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] repl, input logic [3:0] rlen);
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, {$urandom(), 28'($urandom()), plen});
        write_reg(CFG_REPLACEMENT_BYTES, repl);
        write_reg(CFG_REPLACEMENT_LENGTH, {$urandom(), 28'($urandom()), rlen});
        rule_count++;
    endtask

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stream_search_and_replace_core verification failed");
        $finish;
    end

    initial begin
        logic [63:0] pat;
        int          plen_raw;
        int          rlen_raw;
        int          len;
        int          budget;
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset rule deletes 00: a lone 00 closes empty
        @(posedge i_clk);
        send_pace = PACE_BURSTY;
        recv_pace = PACE_RANDOM;
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b1);
        wait_idle();

        // stray indexes, zero pattern length, oversized replacement
        write_reg(CFG_UNUSED_LOW, '1);
        write_reg(CFG_UNUSED_HIGH, '1);
        set_rule(64'h0000_0000_0000_4241, 4'd0, 64'h0807_0605_0403_0201, 4'd15);
        @(posedge i_clk);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);
        wait_idle();

        // oversized pattern length, full-width match deleted at the close
        set_rule('1, 4'd15, {$urandom(), $urandom()}, 4'd0);
        @(posedge i_clk);
        send_pace = PACE_STEADY;
        for (int i = 0; i < 8; i++) begin
            queue_byte(8'hFF, i == 7);
        end
        wait_idle();

        // shorten the pattern while the window holds bytes
        set_rule(64'h4847_4645_4443_4241, 4'd8, 64'h0000_0000_0063_5A7A, 4'd3);
        @(posedge i_clk);
        for (int i = 0; i < 5; i++) begin
            queue_byte(8'h41 + 8'(i), 1'b0);
        end
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        @(posedge i_clk);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);
        wait_idle();

        for (int phase = 0; phase < Phases; phase++) begin
            foreach (alphabet[k]) begin
                alphabet[k] = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < 8; i++) begin
                pat[8*i +: 8] = alphabet[$urandom_range(0, 3)];
            end
            case ($urandom_range(0, 7))
                0:       plen_raw = 0;
                1:       plen_raw = $urandom_range(9, 15);
                default: plen_raw = $urandom_range(1, 8);
            endcase
            rlen_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8);
            set_rule(pat, 4'(plen_raw), {$urandom(), $urandom()}, 4'(rlen_raw));
            @(posedge i_clk);
            send_pace = (phase == 0 || phase == 2) ? PACE_STEADY
                                                   : t_pace'($urandom_range(1, 2));
            recv_pace = (phase == 0) ? PACE_STEADY : t_pace'($urandom_range(1, 2));
            if (phase == 2) begin
                long_hold_req = LongHold;
            end
            budget = PhaseBytes;
            while (budget > 0) begin
                len = $urandom_range(1, 12);
                if (len > budget) begin
                    len = budget;
                end
                budget -= len;
                queue_text(len, budget > 0 || $urandom_range(0, 1) == 1);
            end
            wait_idle();
        end

        $display("%0d text bytes in, %0d output transactions checked, %0d rule settings",
                 accepted, bytes_out, rule_count);
        $display("included deletes, expansions, empty closes and a mid-text pattern cut");
        if (mismatches == 0) begin
            $display("stream_search_and_replace_core verification clean");
        end else begin
            $display("stream_search_and_replace_core verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ssr_pkg.sv
sv/ssr_front.sv
sv/ssr_cmd_queue.sv
sv/ssr_back.sv
sv/stream_search_and_replace_core.sv
dv/stream_search_and_replace_core_test.sv
